// ----- design/efl_pkg.sv -----
package efl_pkg;

  localparam int unsigned HeapBytesDef = 65536;
  localparam logic [31:0] WordBytes    = 32'd4;
  localparam logic [31:0] DwordBytes   = 32'd8;
  localparam logic [31:0] MinBlock     = 32'd16;
  localparam logic [31:0] SizeMask     = ~32'h7;
  localparam logic [31:0] AllocBit     = 32'h1;
  localparam logic [31:0] StartBreak   = 32'd24;
  localparam logic [16:0] ChunkReset   = 17'(1 << 12);
  localparam logic [16:0] LimitReset   = 17'd65536;

  typedef enum logic {
    CFG_CHUNK = 1'b0,
    CFG_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_OOM     = 2'd2
  } status_e;

  typedef struct packed {
    logic        command;
    logic [15:0] request_bytes;
    logic [15:0] release_addr;
  } in_item_t;

  typedef struct packed {
    logic [15:0] payload_addr;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [5:0] {
    S_INIT0, S_INIT1, S_INIT2, S_IDLE, S_DONE,
    S_FIT, S_FIT_H, S_FIT_N,
    S_GROW, S_GW0, S_GW1, S_GW2, S_GW3, S_GW4,
    S_CV_RD, S_CV_H, S_CV_DEC,
    S_CV_S0, S_CV_S1, S_CV_S2, S_CV_S3, S_CV_S4, S_CV_S5,
    S_CV_W0, S_CV_W1,
    S_RL_CHK, S_RL_H, S_RL_F, S_RL_W0, S_RL_W1, S_RL_W2, S_RL_W3,
    S_MG0, S_MG1, S_MG2, S_MG3, S_MG4, S_MG5,
    S_MG_A, S_MG_A1, S_MG_B, S_MG_B1, S_MG_B2, S_MG_C, S_MG_C1, S_MG_C2,
    S_INS0, S_INS1, S_INS2,
    S_RM0, S_RM1, S_RM2, S_RM3, S_RM4, S_RM5
  } state_e;

  function automatic logic [31:0] size_of(logic [31:0] w);
    return w & SizeMask;
  endfunction

endpackage

// ----- design/explicit_free_list_heap_allocator_top.sv -----
// channel   direction  signals
// in        input      in_valid_i, in_stall_o, in_data_i (command, request_bytes, release_addr)
// out       output     out_valid_o, out_stall_i, out_data_o (payload_addr, status)
// cfg       input      cfg_we_i, cfg_idx_i, cfg_data_i (chunk_bytes, heap_limit_bytes)
//
// one transaction at a time through a single-port heap word memory, one access per cycle;
// allocate: a zero request is ignored, else the free list is walked for a block big enough,
// with or without a split; the heap grows when none fits, the new chunk maybe merging down,
// or out of memory is reported; release: rejected, or accepted with or without merges
// after reset S_INIT0 to S_INIT2 write the prologue and epilogue before in_stall_o drops
// a finished result waits in the output register; the next transaction is taken meanwhile
module explicit_free_list_heap_allocator_top #(
  parameter int unsigned HEAP_BYTES = efl_pkg::HeapBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  efl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output efl_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [16:0]        cfg_data_i
);
  import efl_pkg::*;

  localparam int unsigned Wiw = $clog2(HEAP_BYTES / 4);

  logic [16:0]    chunk_q, limit_q;
  logic           mem_we, mem_re;
  logic [Wiw-1:0] mem_addr;
  logic [31:0]    mem_wdata, mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= ChunkReset;
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CHUNK: chunk_q <= cfg_data_i;
        CFG_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  efl_ctrl #(.HEAP_BYTES(HEAP_BYTES)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .chunk_i     (chunk_q),
    .limit_i     (limit_q),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  efl_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- design/efl_mem.sv -----
module efl_mem #(
  parameter int unsigned HEAP_BYTES = efl_pkg::HeapBytesDef
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic                              re_i,
  input  logic [$clog2(HEAP_BYTES/4)-1:0]   addr_i,
  input  logic [31:0]                       wdata_i,
  output logic [31:0]                       rdata_o
);
  import efl_pkg::*;

  localparam int unsigned Words = HEAP_BYTES / 4;

  logic [31:0] mem [Words];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/efl_ctrl.sv -----
module efl_ctrl #(
  parameter int unsigned HEAP_BYTES = efl_pkg::HeapBytesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  efl_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output efl_pkg::out_item_t                out_data_o,
  input  logic [16:0]                       chunk_i,
  input  logic [16:0]                       limit_i,
  output logic                              mem_we_o,
  output logic                              mem_re_o,
  output logic [$clog2(HEAP_BYTES/4)-1:0]   mem_addr_o,
  output logic [31:0]                       mem_wdata_o,
  input  logic [31:0]                       mem_rdata_i
);
  import efl_pkg::*;

  localparam int unsigned HeapWords = HEAP_BYTES / 4;
  localparam int unsigned Wiw       = $clog2(HeapWords);
  localparam int unsigned WalkLimit = HEAP_BYTES / 16 + 1;
  localparam int unsigned Sw        = $clog2(WalkLimit + 1);

  state_e      state_q, state_d, rm_ret_q, rm_ret_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;
  logic [31:0] brk_q, brk_d, head_q, head_d;
  logic        rd_ok_q;
  logic [15:0] rel_q, rel_d, res_q, res_d;
  status_e     stat_q, stat_d;
  logic [31:0] asize_q, asize_d, p_q, p_d, bp_q, bp_d, csize_q, csize_d, tmp_q, tmp_d;
  logic [Sw-1:0] steps_q, steps_d;
  logic [31:0] mg_bp_q, mg_bp_d, mg_p_q, mg_p_d, mg_n_q, mg_n_d;
  logic [31:0] mg_size_q, mg_size_d, mg_psz_q, mg_psz_d, mg_nsz_q, mg_nsz_d;
  logic        mg_pa_q, mg_pa_d, mg_carve_q, mg_carve_d;
  logic [31:0] rm_p_q, rm_p_d, rm_pv_q, rm_pv_d, rm_nx_q, rm_nx_d;

  logic        m_we, m_re, m_ok;
  logic [31:0] m_addr, m_wdata, rdat;
  logic [31:0] ext, dw, gsize, lim, rest, rel32, rsz;

  // out-of-heap reads return zero
  assign rdat  = rd_ok_q ? mem_rdata_i : 32'd0;
  assign m_ok  = (m_addr >> 2) < 32'(HeapWords);
  assign rel32 = {16'd0, rel_q};

  assign mem_we_o    = m_we & m_ok;
  assign mem_re_o    = m_re;
  assign mem_addr_o  = m_addr[Wiw+1:2];
  assign mem_wdata_o = m_wdata;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    ext   = (asize_q > {15'd0, chunk_i}) ? asize_q : {15'd0, chunk_i};
    dw    = ext >> 3;
    gsize = (dw + {31'd0, dw[0]}) << 3;
    lim   = ({15'd0, limit_i} > 32'(HEAP_BYTES)) ? 32'(HEAP_BYTES) : {15'd0, limit_i};
    rest  = csize_q - asize_q;
    rsz   = size_of(rdat);
  end

  always_comb begin
    state_d = state_q;  rm_ret_d = rm_ret_q;
    out_valid_d = out_valid_q;  out_data_d = out_data_q;
    brk_d = brk_q;  head_d = head_q;
    rel_d = rel_q;  res_d = res_q;  stat_d = stat_q;
    asize_d = asize_q;  p_d = p_q;  bp_d = bp_q;  csize_d = csize_q;  tmp_d = tmp_q;
    steps_d = steps_q;
    mg_bp_d = mg_bp_q;  mg_p_d = mg_p_q;  mg_n_d = mg_n_q;  mg_size_d = mg_size_q;
    mg_psz_d = mg_psz_q;  mg_nsz_d = mg_nsz_q;  mg_pa_d = mg_pa_q;  mg_carve_d = mg_carve_q;
    rm_p_d = rm_p_q;  rm_pv_d = rm_pv_q;  rm_nx_d = rm_nx_q;
    m_we = 1'b0;  m_re = 1'b0;  m_addr = 32'd0;  m_wdata = 32'd0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // prologue header, prologue footer and epilogue
      S_INIT0: begin
        m_we = 1'b1;  m_addr = 32'd12;  m_wdata = DwordBytes | AllocBit;  state_d = S_INIT1;
      end
      S_INIT1: begin
        m_we = 1'b1;  m_addr = 32'd16;  m_wdata = DwordBytes | AllocBit;  state_d = S_INIT2;
      end
      S_INIT2: begin
        m_we = 1'b1;  m_addr = 32'd20;  m_wdata = AllocBit;  state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          rel_d  = in_data_i.release_addr;
          res_d  = 16'd0;
          stat_d = STAT_DONE;
          if (in_data_i.command == CMD_RELEASE) begin
            state_d = S_RL_CHK;
          end else if (in_data_i.request_bytes == 16'd0) begin
            stat_d  = STAT_IGNORED;
            state_d = S_DONE;
          end else begin
            asize_d = (in_data_i.request_bytes <= 16'd8) ? MinBlock
                    : (({16'd0, in_data_i.request_bytes} + 32'd15) & SizeMask);
            p_d     = head_q;
            steps_d = '0;
            state_d = S_FIT;
          end
        end
      end
      S_FIT: begin
        if (p_q == 32'd0 || 32'(steps_q) >= 32'(WalkLimit)) begin
          state_d = S_GROW;
        end else begin
          m_re = 1'b1;  m_addr = p_q - WordBytes;  state_d = S_FIT_H;
        end
      end
      S_FIT_H: begin
        if (rsz >= asize_q) begin
          bp_d = p_q;  state_d = S_CV_RD;
        end else begin
          m_re = 1'b1;  m_addr = p_q + WordBytes;  state_d = S_FIT_N;
        end
      end
      S_FIT_N: begin
        p_d = rdat;  steps_d = steps_q + Sw'(1);  state_d = S_FIT;
      end
      S_GROW: begin
        if (brk_q > lim || gsize > lim - brk_q) begin
          stat_d = STAT_OOM;  state_d = S_DONE;
        end else begin
          bp_d = brk_q;  csize_d = gsize;  brk_d = brk_q + gsize;  state_d = S_GW0;
        end
      end
      S_GW0: begin
        m_we = 1'b1;  m_addr = bp_q - WordBytes;  m_wdata = csize_q;  state_d = S_GW1;
      end
      S_GW1: begin
        m_we = 1'b1;  m_addr = bp_q + csize_q - DwordBytes;  m_wdata = csize_q;
        state_d = S_GW2;
      end
      S_GW2: begin
        m_we = 1'b1;  m_addr = bp_q + WordBytes;  state_d = S_GW3;
      end
      S_GW3: begin
        m_we = 1'b1;  m_addr = bp_q;  state_d = S_GW4;
      end
      S_GW4: begin
        // new epilogue
        m_we = 1'b1;  m_addr = bp_q + csize_q - WordBytes;  m_wdata = AllocBit;
        mg_bp_d = bp_q;  mg_carve_d = 1'b1;  state_d = S_MG0;
      end
      S_CV_RD: begin
        res_d = bp_q[15:0];
        m_re = 1'b1;  m_addr = bp_q - WordBytes;  state_d = S_CV_H;
      end
      S_CV_H: begin
        csize_d = rsz;  rm_p_d = bp_q;  rm_ret_d = S_CV_DEC;  state_d = S_RM0;
      end
      S_CV_DEC: begin
        state_d = (rest >= MinBlock) ? S_CV_S0 : S_CV_W0;
      end
      S_CV_S0: begin
        m_we = 1'b1;  m_addr = bp_q - WordBytes;  m_wdata = asize_q | AllocBit;
        state_d = S_CV_S1;
      end
      S_CV_S1: begin
        m_we = 1'b1;  m_addr = bp_q + asize_q - DwordBytes;  m_wdata = asize_q | AllocBit;
        state_d = S_CV_S2;
      end
      S_CV_S2: begin
        m_we = 1'b1;  m_addr = bp_q + asize_q - WordBytes;  m_wdata = rest;
        state_d = S_CV_S3;
      end
      S_CV_S3: begin
        m_we = 1'b1;  m_addr = bp_q + asize_q + rest - DwordBytes;  m_wdata = rest;
        state_d = S_CV_S4;
      end
      S_CV_S4: begin
        m_we = 1'b1;  m_addr = bp_q + asize_q + WordBytes;  state_d = S_CV_S5;
      end
      S_CV_S5: begin
        m_we = 1'b1;  m_addr = bp_q + asize_q;
        mg_bp_d = bp_q + asize_q;  mg_carve_d = 1'b0;  state_d = S_MG0;
      end
      S_CV_W0: begin
        m_we = 1'b1;  m_addr = bp_q - WordBytes;  m_wdata = csize_q | AllocBit;
        state_d = S_CV_W1;
      end
      S_CV_W1: begin
        m_we = 1'b1;  m_addr = bp_q + csize_q - DwordBytes;  m_wdata = csize_q | AllocBit;
        state_d = S_DONE;
      end
      S_RL_CHK: begin
        if (rel32 != 32'd0 && rel32[2:0] == 3'd0 && rel32 >= StartBreak && rel32 < brk_q) begin
          m_re = 1'b1;  m_addr = rel32 - WordBytes;  state_d = S_RL_H;
        end else begin
          stat_d = STAT_IGNORED;  state_d = S_DONE;
        end
      end
      S_RL_H: begin
        tmp_d = rdat;
        if (rdat[0] && rsz >= MinBlock && rsz <= brk_q - rel32) begin
          m_re = 1'b1;  m_addr = rel32 + rsz - DwordBytes;  state_d = S_RL_F;
        end else begin
          stat_d = STAT_IGNORED;  state_d = S_DONE;
        end
      end
      S_RL_F: begin
        if (rdat == tmp_q) begin
          state_d = S_RL_W0;
        end else begin
          stat_d = STAT_IGNORED;  state_d = S_DONE;
        end
      end
      S_RL_W0: begin
        m_we = 1'b1;  m_addr = rel32 - WordBytes;  m_wdata = size_of(tmp_q);  state_d = S_RL_W1;
      end
      S_RL_W1: begin
        m_we = 1'b1;  m_addr = rel32 + size_of(tmp_q) - DwordBytes;  m_wdata = size_of(tmp_q);
        state_d = S_RL_W2;
      end
      S_RL_W2: begin
        m_we = 1'b1;  m_addr = rel32 + WordBytes;  state_d = S_RL_W3;
      end
      S_RL_W3: begin
        m_we = 1'b1;  m_addr = rel32;
        mg_bp_d = rel32;  mg_carve_d = 1'b0;  state_d = S_MG0;
      end
      // coalesce: gather both neighbors first, then pick the case
      S_MG0: begin
        m_re = 1'b1;  m_addr = mg_bp_q - DwordBytes;  state_d = S_MG1;
      end
      S_MG1: begin
        mg_p_d = mg_bp_q - rsz;
        m_re = 1'b1;  m_addr = mg_bp_q - rsz - WordBytes;  state_d = S_MG2;
      end
      S_MG2: begin
        mg_psz_d = rsz;
        m_re = 1'b1;  m_addr = mg_p_q + rsz - DwordBytes;  state_d = S_MG3;
      end
      S_MG3: begin
        mg_pa_d = rdat[0];
        m_re = 1'b1;  m_addr = mg_bp_q - WordBytes;  state_d = S_MG4;
      end
      S_MG4: begin
        mg_size_d = rsz;  mg_n_d = mg_bp_q + rsz;
        m_re = 1'b1;  m_addr = mg_bp_q + rsz - WordBytes;  state_d = S_MG5;
      end
      S_MG5: begin
        if (mg_pa_q && rdat[0]) begin
          state_d = S_INS0;
        end else if (mg_pa_q) begin
          mg_size_d = mg_size_q + rsz;
          rm_p_d = mg_n_q;  rm_ret_d = S_MG_A;  state_d = S_RM0;
        end else if (rdat[0]) begin
          mg_size_d = mg_size_q + mg_psz_q;
          rm_p_d = mg_p_q;  rm_ret_d = S_MG_B;  state_d = S_RM0;
        end else begin
          mg_size_d = mg_size_q + rsz + mg_psz_q;  mg_nsz_d = rsz;
          rm_p_d = mg_p_q;  rm_ret_d = S_MG_C;  state_d = S_RM0;
        end
      end
      S_MG_A: begin
        m_we = 1'b1;  m_addr = mg_bp_q - WordBytes;  m_wdata = mg_size_q;  state_d = S_MG_A1;
      end
      S_MG_A1: begin
        m_we = 1'b1;  m_addr = mg_bp_q + mg_size_q - DwordBytes;  m_wdata = mg_size_q;
        state_d = S_INS0;
      end
      S_MG_B: begin
        m_re = 1'b1;  m_addr = mg_bp_q - WordBytes;  state_d = S_MG_B1;
      end
      S_MG_B1: begin
        m_we = 1'b1;  m_addr = mg_bp_q + rsz - DwordBytes;  m_wdata = mg_size_q;
        state_d = S_MG_B2;
      end
      S_MG_B2: begin
        m_we = 1'b1;  m_addr = mg_p_q - WordBytes;  m_wdata = mg_size_q;
        mg_bp_d = mg_p_q;  state_d = S_INS0;
      end
      S_MG_C: begin
        rm_p_d = mg_n_q;  rm_ret_d = S_MG_C1;  state_d = S_RM0;
      end
      S_MG_C1: begin
        m_we = 1'b1;  m_addr = mg_n_q + mg_nsz_q - DwordBytes;  m_wdata = mg_size_q;
        state_d = S_MG_C2;
      end
      S_MG_C2: begin
        m_we = 1'b1;  m_addr = mg_p_q - WordBytes;  m_wdata = mg_size_q;
        mg_bp_d = mg_p_q;  state_d = S_INS0;
      end
      // push at list head
      S_INS0: begin
        if (head_q != 32'd0) begin
          m_we = 1'b1;  m_addr = head_q;  m_wdata = mg_bp_q;
        end
        state_d = S_INS1;
      end
      S_INS1: begin
        m_we = 1'b1;  m_addr = mg_bp_q + WordBytes;  m_wdata = head_q;  state_d = S_INS2;
      end
      S_INS2: begin
        m_we = 1'b1;  m_addr = mg_bp_q;  head_d = mg_bp_q;
        if (mg_carve_q) begin
          bp_d = mg_bp_q;  state_d = S_CV_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      // unlink rm_p_q, then return to rm_ret_q
      S_RM0: begin
        m_re = 1'b1;  m_addr = rm_p_q;  state_d = S_RM1;
      end
      S_RM1: begin
        rm_pv_d = rdat;
        m_re = 1'b1;  m_addr = rm_p_q + WordBytes;  state_d = S_RM2;
      end
      S_RM2: begin
        rm_nx_d = rdat;
        if (rdat != 32'd0) begin
          m_we = 1'b1;  m_addr = rdat;  m_wdata = rm_pv_q;
        end
        if (rm_pv_q == 32'd0) begin
          head_d = rdat;
        end
        state_d = S_RM3;
      end
      S_RM3: begin
        if (rm_pv_q != 32'd0) begin
          m_we = 1'b1;  m_addr = rm_pv_q + WordBytes;  m_wdata = rm_nx_q;
        end
        state_d = S_RM4;
      end
      S_RM4: begin
        m_we = 1'b1;  m_addr = rm_p_q + WordBytes;  state_d = S_RM5;
      end
      S_RM5: begin
        m_we = 1'b1;  m_addr = rm_p_q;  state_d = rm_ret_q;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d.payload_addr = res_q;
          out_data_d.status       = stat_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT0;
      out_valid_q <= 1'b0;
      brk_q       <= StartBreak;
      head_q      <= 32'd0;
      rd_ok_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      brk_q       <= brk_d;
      head_q      <= head_d;
      rd_ok_q     <= m_re & m_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    rm_ret_q <= rm_ret_d;  out_data_q <= out_data_d;
    rel_q <= rel_d;  res_q <= res_d;  stat_q <= stat_d;
    asize_q <= asize_d;  p_q <= p_d;  bp_q <= bp_d;  csize_q <= csize_d;  tmp_q <= tmp_d;
    steps_q <= steps_d;
    mg_bp_q <= mg_bp_d;  mg_p_q <= mg_p_d;  mg_n_q <= mg_n_d;  mg_size_q <= mg_size_d;
    mg_psz_q <= mg_psz_d;  mg_nsz_q <= mg_nsz_d;  mg_pa_q <= mg_pa_d;
    mg_carve_q <= mg_carve_d;
    rm_p_q <= rm_p_d;  rm_pv_q <= rm_pv_d;  rm_nx_q <= rm_nx_d;
  end

endmodule

// ----- tb/tb_explicit_free_list_heap_allocator_top.sv -----
module tb_explicit_free_list_heap_allocator_top;
  import efl_pkg::*;

  localparam int unsigned HeapWords = HeapBytesDef / 4;
  localparam int unsigned WalkMax = HeapBytesDef / 16 + 1;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned LiveMax = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [16:0] cfg_data_i = '0;

  explicit_free_list_heap_allocator_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // heap mirror
  logic [31:0] heap_mem [HeapWords];
  int unsigned brk;
  int unsigned flist_head;
  int unsigned grow_min;
  int unsigned brk_cap;

  out_item_t pending_results[$];
  int unsigned live_blocks[$];
  int unsigned past_blocks[$];

  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned cycles = 0;
  int unsigned n_alloc = 0, n_free = 0, n_oom = 0, n_ign = 0;
  int unsigned burst_left = 0;
  int unsigned hold_cycles = 0;

  function automatic logic [31:0] hrd(int unsigned a);
    return ((a >> 2) < HeapWords) ? heap_mem[a >> 2] : 32'd0;
  endfunction

  function automatic void hwr(int unsigned a, logic [31:0] v);
    if ((a >> 2) < HeapWords) heap_mem[a >> 2] = v;
  endfunction

  function automatic int unsigned blen(int unsigned bp);
    return hrd(bp - 4) & SizeMask;
  endfunction

  function automatic void unlink(int unsigned p);
    int unsigned pv, nx;
    pv = hrd(p);
    nx = hrd(p + 4);
    if (pv == 0) begin
      if (nx != 0) hwr(nx, 0);
      flist_head = nx;
    end else begin
      if (nx != 0) hwr(nx, pv);
      hwr(pv + 4, nx);
    end
    hwr(p + 4, 0);
    hwr(p, 0);
  endfunction

  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned p, n, sz, nsz;
    logic pa, na;
    p = bp - (hrd(bp - 8) & SizeMask);
    n = bp + blen(bp);
    pa = ((hrd(p + blen(p) - 8) & AllocBit) != 0);
    na = ((hrd(n - 4) & AllocBit) != 0);
    sz = blen(bp);
    if (pa && !na) begin
      sz += blen(n);
      unlink(n);
      hwr(bp - 4, sz);
      hwr(bp + sz - 8, sz);
    end else if (!pa && na) begin
      sz += blen(p);
      unlink(p);
      hwr(bp + blen(bp) - 8, sz);
      hwr(p - 4, sz);
      bp = p;
    end else if (!pa && !na) begin
      nsz = blen(n);
      sz += nsz + blen(p);
      unlink(p);
      unlink(n);
      hwr(n + nsz - 8, sz);
      hwr(p - 4, sz);
      bp = p;
    end
    // merged block goes to the list head
    if (flist_head != 0) hwr(flist_head, bp);
    hwr(bp + 4, flist_head);
    hwr(bp, 0);
    flist_head = bp;
    return bp;
  endfunction

  function automatic int unsigned grow_heap(int unsigned ext);
    int unsigned dw, sz, lim, bp;
    dw = ext >> 3;
    sz = (dw + (dw & 1)) << 3;
    lim = (brk_cap > HeapBytesDef) ? HeapBytesDef : brk_cap;
    if (brk > lim || sz > lim - brk) return 0;
    bp = brk;
    brk += sz;
    hwr(bp - 4, sz);
    hwr(bp + sz - 8, sz);
    hwr(bp + 4, 0);
    hwr(bp, 0);
    hwr(bp + sz - 4, AllocBit);
    return coalesce(bp);
  endfunction

  function automatic void place(int unsigned bp, int unsigned asz);
    int unsigned csz, rest, r;
    csz = blen(bp);
    unlink(bp);
    if (csz - asz >= MinBlock) begin
      rest = csz - asz;
      hwr(bp - 4, asz | AllocBit);
      hwr(bp + asz - 8, asz | AllocBit);
      r = bp + asz;
      hwr(r - 4, rest);
      hwr(r + rest - 8, rest);
      hwr(r + 4, 0);
      hwr(r, 0);
      void'(coalesce(r));
    end else begin
      hwr(bp - 4, csz | AllocBit);
      hwr(bp + csz - 8, csz | AllocBit);
    end
  endfunction

  function automatic out_item_t predict_heap_op(in_item_t it);
    out_item_t r;
    int unsigned asz, bp, steps, h, s;
    logic ok;
    r = '0;
    if (it.command == CMD_ALLOC) begin
      if (it.request_bytes == 0) begin
        r.status = STAT_IGNORED;
      end else begin
        asz = (it.request_bytes <= 8) ? 16 : 8 * ((it.request_bytes + 15) / 8);
        bp = flist_head;
        steps = 0;
        while (bp != 0 && steps < WalkMax && blen(bp) < asz) begin
          bp = hrd(bp + 4);
          steps++;
        end
        if (steps >= WalkMax) bp = 0;
        if (bp == 0) bp = grow_heap((asz > grow_min) ? asz : grow_min);
        if (bp == 0) begin
          r.status = STAT_OOM;
        end else begin
          place(bp, asz);
          r.payload_addr = bp[15:0];
          r.status = STAT_DONE;
        end
      end
    end else begin
      ok = 1'b0;
      bp = it.release_addr;
      if (bp != 0 && bp[2:0] == 0 && bp >= StartBreak && bp < brk) begin
        h = hrd(bp - 4);
        s = h & SizeMask;
        if ((h & AllocBit) != 0 && s >= MinBlock && s <= brk - bp && hrd(bp + s - 8) == h)
          ok = 1'b1;
      end
      if (!ok) begin
        r.status = STAT_IGNORED;
      end else begin
        s = blen(bp);
        hwr(bp - 4, s);
        hwr(bp + s - 8, s);
        hwr(bp + 4, 0);
        hwr(bp, 0);
        void'(coalesce(bp));
        r.status = STAT_DONE;
      end
    end
    return r;
  endfunction

  // sender: called at a falling edge, returns at a falling edge
  task automatic send_item(in_item_t it);
    out_item_t r;
    in_valid_i = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_heap_op(it);
    pending_results.push_back(r);
    if (it.command == CMD_ALLOC && r.status == STAT_DONE) begin
      live_blocks.push_back(r.payload_addr);
      past_blocks.push_back(r.payload_addr);
      if (past_blocks.size() > 64) void'(past_blocks.pop_front());
      n_alloc++;
    end else if (r.status == STAT_DONE) n_free++;
    else if (r.status == STAT_OOM) n_oom++;
    else n_ign++;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end else burst_left--;
  endtask

  task automatic do_alloc(int unsigned nbytes);
    in_item_t it;
    it = '0;
    it.command = CMD_ALLOC;
    it.request_bytes = nbytes[15:0];
    it.release_addr = 16'($urandom);
    send_item(it);
  endtask

  task automatic do_release(int unsigned a);
    in_item_t it;
    it = '0;
    it.command = CMD_RELEASE;
    it.release_addr = a[15:0];
    it.request_bytes = 16'($urandom);
    send_item(it);
  endtask

  task automatic release_live(int unsigned idx);
    int unsigned a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    do_release(a);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned v);
    wait_drained();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = v[16:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_CHUNK) grow_min = v[16:0];
    else brk_cap = v[16:0];
  endtask

  // noise releases that never touch words inside the heap that were never written
  task automatic release_noise();
    int unsigned a;
    case ($urandom_range(0, 3))
      0: a = 0;
      1: a = $urandom_range(0, 23);
      2: a = ($urandom_range(0, 8191) << 3) | $urandom_range(1, 7);
      default: a = (brk >= 65536) ? (16'($urandom) | 16'h1) : $urandom_range(brk, 65535);
    endcase
    do_release(a);
  endtask

  task automatic test_directed();
    do_alloc(0);
    do_alloc(1);
    do_alloc(8);
    do_alloc(9);
    do_alloc(65535);
    do_release(0);
    do_release(16'hFFFF);
    do_release(20);
    do_release(61444);
    do_alloc(24);
    do_alloc(40);
    do_alloc(16);
    do_alloc(100);
    do_alloc(3000);
    // neighbors both allocated, then both free, then prologue side, then top side
    release_live(4);
    release_live(5);
    release_live(4);
    do_release(past_blocks[past_blocks.size() - 2]);
    release_live(3);
    release_live(3);
    release_live(live_blocks.size() - 1);
  endtask

  task automatic test_extreme_config();
    write_reg(CFG_LIMIT, 24);
    write_reg(CFG_CHUNK, 16);
    do_alloc(5000);
    do_alloc(1);
    if (live_blocks.size() != 0) release_live(0);
    write_reg(CFG_LIMIT, 65536);
    write_reg(CFG_CHUNK, 65536);
    do_alloc(50000);
    do_alloc(60000);
    do_alloc(32);
  endtask

  task automatic random_items(int unsigned target);
    int unsigned useful, pick;
    useful = 0;
    while (useful < target) begin
      pick = $urandom_range(0, 99);
      if (live_blocks.size() > LiveMax || (pick >= 50 && pick < 85 && live_blocks.size() != 0))
        release_live($urandom_range(0, live_blocks.size() - 1));
      else if (pick < 45) do_alloc($urandom_range(1, 200));
      else if (pick < 50) do_alloc((pick & 1) ? $urandom_range(201, 4000) : 16'($urandom));
      else if (pick < 90 && past_blocks.size() != 0)
        do_release(past_blocks[$urandom_range(0, past_blocks.size() - 1)]);
      else release_noise();
      if (n_ign == 0 || pending_results[$].status != STAT_IGNORED) useful++;
    end
  endtask

  task automatic test_random();
    write_reg(CFG_CHUNK, 4096);
    random_items(500);
    write_reg(CFG_CHUNK, 16);
    write_reg(CFG_LIMIT, $urandom_range(2048, 16384));
    random_items(450);
    write_reg(CFG_CHUNK, $urandom_range(16, 8192));
    write_reg(CFG_LIMIT, 65536);
    random_items(500);
  endtask

  task automatic test_backpressure();
    hold_cycles = 600;
    repeat (20) do_alloc($urandom_range(1, 64));
    repeat (10) if (live_blocks.size() != 0) release_live(0);
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case ((cycles >> 7) % 4)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        2: out_stall_i <= (cycles[2:0] < 3);
        default: out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.payload_addr !== want.payload_addr || out_data_o.status !== want.status)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: addr exp %0d got %0d, status exp %0d got %0d",
                     checked, want.payload_addr, out_data_o.payload_addr,
                     want.status, out_data_o.status);
        end
      end
    end
  end

  initial begin
    foreach (heap_mem[i]) heap_mem[i] = '0;
    heap_mem[3] = DwordBytes | AllocBit;
    heap_mem[4] = DwordBytes | AllocBit;
    heap_mem[5] = AllocBit;
    brk = StartBreak;
    flist_head = 0;
    grow_min = ChunkReset;
    brk_cap = LimitReset;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_extreme_config();
    test_random();
    wait_drained();
    $display("covered %0d transactions: %0d allocations, %0d releases, %0d out of memory,",
             checked, n_alloc, n_free, n_oom);
    $display("%0d ignored, over several chunk and heap limit settings", n_ign);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/efl_pkg.sv
design/efl_mem.sv
design/efl_ctrl.sv
design/explicit_free_list_heap_allocator_top.sv
tb/tb_explicit_free_list_heap_allocator_top.sv
